>>> hdl/rac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rac_pkg
// shared types, widths and codes of the real-time admission control block
// ----------------------------------------------------------------------------
package rac_pkg;

  // number of cores that hold a budget entry
  localparam int NUM_CORES = 8;
  localparam int IDX_W     = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

  // field widths
  localparam int CORE_W     = 3;
  localparam int CORE_EXT_W = 9;   // holds any core count up to 256
  localparam int TIME_W     = 32;
  localparam int BW_W       = 10;
  localparam int CAP_W      = 10;
  localparam int STATUS_W   = 2;
  localparam int PRIO_W     = 5;

  // divider: numerator is exec_time * 1000, quotient never above 1000
  localparam int PER_MILLE = 1000;
  localparam int NUM_W     = TIME_W + BW_W;
  localparam int DIV_STEPS = BW_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_EDF_CAP = 1'b0;
  localparam logic REG_RMS_CAP = 1'b1;
  localparam logic [CAP_W-1:0] EDF_CAP_RESET = CAP_W'(1000);
  localparam logic [CAP_W-1:0] RMS_CAP_RESET = CAP_W'(690);

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ADMIT   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

  // rate monotonic priority bands
  localparam logic [TIME_W-1:0] RMS_LIMIT_HI  = TIME_W'(10);
  localparam logic [TIME_W-1:0] RMS_LIMIT_MID = TIME_W'(50);
  localparam logic [TIME_W-1:0] RMS_LIMIT_LO  = TIME_W'(100);
  localparam logic [PRIO_W-1:0] PRIO_HI   = PRIO_W'(30);
  localparam logic [PRIO_W-1:0] PRIO_MID  = PRIO_W'(25);
  localparam logic [PRIO_W-1:0] PRIO_LO   = PRIO_W'(20);
  localparam logic [PRIO_W-1:0] PRIO_BASE = PRIO_W'(15);
  localparam logic [PRIO_W-1:0] PRIO_NONE = PRIO_W'(0);

  // one per-core entry of the state memory
  typedef struct packed {
    logic [CAP_W-1:0] cap;
    logic [BW_W-1:0]  used;
  } state_entry_t;

  // write request into the state memory
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    state_entry_t     data;
  } mem_wr_t;

  // divider status toward the controller
  typedef struct packed {
    logic            done;
    logic [BW_W-1:0] quot;
  } div_status_t;

endpackage
`default_nettype wire

>>> hdl/rac_state_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rac_state_ram
// per-core cap and budget memory, one write and one registered read port
// ----------------------------------------------------------------------------
module rac_state_ram (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  rd_en,
  input  wire logic [rac_pkg::IDX_W-1:0] rd_addr,
  output rac_pkg::state_entry_t      rd_data,
  input  wire rac_pkg::mem_wr_t      wr
);
  import rac_pkg::*;

  state_entry_t         mem [NUM_CORES];
  logic [NUM_CORES-1:0] valid;
  state_entry_t         mem_q;
  logic                 vld_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= valid[rd_addr];
      end
    end
  end

  assign rd_data = vld_q ? mem_q : '0;

endmodule
`default_nettype wire

>>> hdl/rac_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rac_divider
// per-mille bandwidth, exec_time * 1000 / period, one quotient bit a cycle
// ----------------------------------------------------------------------------
module rac_divider (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [rac_pkg::TIME_W-1:0] exec_time,
  input  wire logic [rac_pkg::TIME_W-1:0] period,
  output rac_pkg::div_status_t            status
);
  import rac_pkg::*;

  logic [NUM_W-1:0]     rem;
  logic [NUM_W-1:0]     den;
  logic [BW_W-1:0]      quot;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic                 take;

  // quotient < 1024 since exec_time <= period, so only low bits are tried
  assign take = (rem >= den);

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= NUM_W'(exec_time) * NUM_W'(PER_MILLE);
      den  <= NUM_W'(period) << (DIV_STEPS - 1);
      quot <= '0;
    end else if (busy) begin
      if (take) begin
        rem <= rem - den;
      end
      quot <= {quot[BW_W-2:0], take};
      den  <= den >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.done = done;
  assign status.quot = quot;

endmodule
`default_nettype wire

>>> hdl/realtime_admission_control_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// realtime_admission_control_top
// utilization-based admission of real-time tasks onto per-core budgets
// ----------------------------------------------------------------------------
// One request at a time. A valid request runs a memory read overlapped with
// the constant multiply, ten restoring divide steps for the 10-bit per-mille
// bandwidth, the decision, and the result load together with the write-back
// of the core entry. An invalid request or a core out of range skips the
// divide and goes from the read straight to the result load. The result sits
// in an output register; a stalled result holds the controller before
// write-back, so no beat is lost. Cap and budget of every core live in a
// small memory whose entries read as zero until written, so nothing is swept
// after reset. Caps are set through two APB registers: edf_budget_cap at 0x0,
// rms_budget_cap at 0x4.
// ----------------------------------------------------------------------------
module realtime_admission_control_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // request channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           mode,
  input  wire logic [rac_pkg::CORE_W-1:0]     core,
  input  wire logic [rac_pkg::TIME_W-1:0]     exec_time,
  input  wire logic [rac_pkg::TIME_W-1:0]     period,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [rac_pkg::STATUS_W-1:0]        status,
  output logic [rac_pkg::PRIO_W-1:0]          priority_res,
  output logic [rac_pkg::BW_W-1:0]            bandwidth,
  output logic [rac_pkg::BW_W-1:0]            used_after,
  // configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [rac_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [rac_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rac_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import rac_pkg::*;

  // controller states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;

  // configuration registers
  logic [CAP_W-1:0] edf_cap;
  logic [CAP_W-1:0] rms_cap;
  logic             cfg_wr;

  // request held for the whole job
  logic              mode_q;
  logic [IDX_W-1:0]  idx_q;
  logic [TIME_W-1:0] period_q;
  logic              bad_q;
  logic              oor_q;

  // pending result and write-back
  logic [STATUS_W-1:0] res_status;
  logic [PRIO_W-1:0]   res_prio;
  logic [BW_W-1:0]     res_bw;
  logic [BW_W-1:0]     res_used;
  mem_wr_t             wr_q;
  mem_wr_t             mem_wr;

  // request decode
  logic [CORE_EXT_W-1:0] core_ext;
  logic [IDX_W-1:0]      in_idx;
  logic                  in_oor;
  logic                  in_bad;
  logic                  accept;

  state_entry_t rd_data;
  div_status_t  div_st;

  // decision datapath
  logic [CAP_W-1:0] cap_eff;
  logic [BW_W:0]    sum;
  logic             refuse;
  logic [PRIO_W-1:0] rms_prio;
  logic             out_slot;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      edf_cap <= EDF_CAP_RESET;
      rms_cap <= RMS_CAP_RESET;
    end else if (cfg_wr) begin
      // register picked by the word address, byte offset ignored
      case (paddr[2])
        REG_EDF_CAP: edf_cap <= pwdata[CAP_W-1:0];
        REG_RMS_CAP: rms_cap <= pwdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_EDF_CAP: prdata = CFG_DATA_W'(edf_cap);
      REG_RMS_CAP: prdata = CFG_DATA_W'(rms_cap);
      default:     prdata = '0;
    endcase
  end

  // ---------------- request decode ----------------
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign core_ext = CORE_EXT_W'(core);
  assign in_idx   = core_ext[IDX_W-1:0];
  assign in_oor   = (core_ext >= CORE_EXT_W'(NUM_CORES));
  // zero period, or more work than period
  assign in_bad   = (period == '0) || (exec_time > period);

  // ---------------- state memory and divider ----------------
  // the job reads its entry at accept and writes it back at the end;
  // a new read only follows an idle cycle, so no forwarding is needed
  rac_state_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (in_idx),
    .rd_data (rd_data),
    .wr      (mem_wr)
  );

  // divider starts on accept of a valid request for a core in range, in parallel with the memory read
  rac_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && !in_oor && !in_bad),
    .exec_time (exec_time),
    .period    (period),
    .status    (div_st)
  );

  // ---------------- decision ----------------
  // first valid request of a core latches the cap of its policy
  assign cap_eff = (rd_data.cap == '0) ? (mode_q ? rms_cap : edf_cap) : rd_data.cap;
  assign sum     = {1'b0, rd_data.used} + {1'b0, div_st.quot};
  assign refuse  = (sum > {1'b0, cap_eff});

  always_comb begin
    if (period_q <= RMS_LIMIT_HI) begin
      rms_prio = PRIO_HI;
    end else if (period_q <= RMS_LIMIT_MID) begin
      rms_prio = PRIO_MID;
    end else if (period_q <= RMS_LIMIT_LO) begin
      rms_prio = PRIO_LO;
    end else begin
      rms_prio = PRIO_BASE;
    end
  end

  // result register free, or freed at this edge
  assign out_slot = !out_valid || out_ready;

  // write-back fires together with the result load
  always_comb begin
    mem_wr    = wr_q;
    mem_wr.en = wr_q.en && (state == S_OUT) && out_slot;
  end

  // ---------------- controller ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      wr_q.en <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          // entry is readable now; invalid requests and out-of-range cores finish without write-back
          if (oor_q || bad_q) begin
            wr_q.en <= 1'b0;
            state   <= S_OUT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            wr_q.en        <= 1'b1;
            wr_q.addr      <= idx_q;
            wr_q.data.cap  <= cap_eff;
            wr_q.data.used <= refuse ? rd_data.used : sum[BW_W-1:0];
            state          <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_slot) begin
            wr_q.en <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // job payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q   <= mode;
      idx_q    <= in_idx;
      period_q <= period;
      bad_q    <= in_bad;
      oor_q    <= in_oor;
    end
    if (state == S_READ) begin
      res_status <= ST_INVALID;
      res_prio   <= PRIO_NONE;
      res_bw     <= '0;
      // out-of-range core reports zero budget
      res_used   <= oor_q ? '0 : rd_data.used;
    end else if ((state == S_DIV) && div_st.done) begin
      res_status <= refuse ? ST_REFUSED : ST_ADMIT;
      res_prio   <= (!refuse && mode_q) ? rms_prio : PRIO_NONE;
      res_bw     <= div_st.quot;
      res_used   <= refuse ? rd_data.used : sum[BW_W-1:0];
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_OUT) && out_slot) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_slot) begin
      status       <= res_status;
      priority_res <= res_prio;
      bandwidth    <= res_bw;
      used_after   <= res_used;
    end
  end

endmodule
`default_nettype wire

>>> hdl/rac_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rac_checker
// port-level checks of the admission control block, bound to the top level
// ----------------------------------------------------------------------------
module rac_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [rac_pkg::STATUS_W-1:0] status,
  input wire logic [rac_pkg::PRIO_W-1:0]   priority_res,
  input wire logic [rac_pkg::BW_W-1:0]     bandwidth,
  input wire logic [rac_pkg::BW_W-1:0]     used_after
);
  import rac_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(bandwidth)
      && $stable(used_after) && $stable(priority_res))
    else $error("result beat changed while stalled");

  // one request in flight at a time
  a_one_job: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while a job is running");

  // invalid requests carry no bandwidth and no priority
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_INVALID) |-> (bandwidth == '0) && (priority_res == PRIO_NONE))
    else $error("invalid request reports bandwidth or priority");

  // priority only on admission
  a_prio_admit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_ADMIT) |-> (priority_res == PRIO_NONE))
    else $error("priority on a request that was not admitted");

endmodule

bind realtime_admission_control_top rac_checker u_rac_checker (.*);
`default_nettype wire
